### hdl/cist_pkg.sv
// Shared types, constants and the built-in identifier list for the CAN identifier
// snapshot table. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cist_pkg;

   // Row count defaults and limits
   localparam int ROWS_DEFAULT = 27;
   localparam int BUILTIN_IDS  = 27;
   localparam int ROW_SEL_W    = 6;   // enough for the largest table (64 rows)
   localparam int QUEUE_DEPTH  = 2;
   localparam logic [3:0] FULL_LEN = 4'd8;

   // Request kinds
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_DUMP  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [28:0] frame_id;
      logic        is_extended;
      logic [3:0]  frame_len;
      logic [63:0] payload;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  row_index;
      logic [10:0] row_ident;
      logic        row_valid;
      logic [31:0] word_high;
      logic [31:0] word_low;
      logic [31:0] frames_seen;
      logic [28:0] recent_ident;
      logic [3:0]  recent_len;
      logic        last_row;
   } rsp_item_type;

   // Classified command handed from front to back
   typedef struct packed {
      logic                 is_dump;
      logic                 hit;
      logic [ROW_SEL_W-1:0] row;
      logic [28:0]          ident;
      logic [3:0]           len;
      logic [63:0]          data;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_DUMP
   } back_state_type;

   // Fixed identifier of each row; rows past the built-in list read as zero
   function automatic logic [10:0] row_ident_of(input logic [ROW_SEL_W-1:0] row);
      logic [10:0] ident;
      case (row)
         6'd0:    ident = 11'h402;
         6'd1:    ident = 11'h403;
         6'd2:    ident = 11'h40B;
         6'd3:    ident = 11'h40C;
         6'd4:    ident = 11'h404;
         6'd5:    ident = 11'h40E;
         6'd6:    ident = 11'h405;
         6'd7:    ident = 11'h406;
         6'd8:    ident = 11'h407;
         6'd9:    ident = 11'h422;
         6'd10:   ident = 11'h423;
         6'd11:   ident = 11'h42B;
         6'd12:   ident = 11'h42C;
         6'd13:   ident = 11'h424;
         6'd14:   ident = 11'h42E;
         6'd15:   ident = 11'h425;
         6'd16:   ident = 11'h426;
         6'd17:   ident = 11'h427;
         6'd18:   ident = 11'h501;
         6'd19:   ident = 11'h504;
         6'd20:   ident = 11'h581;
         6'd21:   ident = 11'h582;
         6'd22:   ident = 11'h583;
         6'd23:   ident = 11'h585;
         6'd24:   ident = 11'h586;
         6'd25:   ident = 11'h401;
         6'd26:   ident = 11'h421;
         default: ident = 11'h000;
      endcase
      return ident;
   endfunction

endpackage

### hdl/cist_front.sv
// Front end: takes request beats, masks the identifier, finds the matching row
// and pushes a classified command into the queue. Depends on cist_pkg.
`timescale 1ns / 1ps
module cist_front import cist_pkg::*; #(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   input  logic         q_full,
   output logic         q_push,
   output cmd_type      q_cmd
);

   logic [28:0] ident;
   logic        found;
   logic [ROW_SEL_W-1:0] found_row;

   // Accept whenever the queue has room
   assign busy   = q_full;
   assign q_push = start && !q_full;

   // Standard frames keep only the low 11 identifier bits
   assign ident = req_item.is_extended ? req_item.frame_id
                                       : {18'd0, req_item.frame_id[10:0]};

   // Parallel compare against every built-in row, lowest row wins
   always_comb begin
      found     = 1'b0;
      found_row = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (r < BUILTIN_IDS &&
             row_ident_of(ROW_SEL_W'(r)) == ident[10:0] && ident[28:11] == 18'd0) begin
            found     = 1'b1;
            found_row = ROW_SEL_W'(r);
         end
      end
   end

   always_comb begin
      q_cmd.is_dump = (req_item.req_type == REQ_DUMP);
      q_cmd.hit     = found && !req_item.is_extended && (req_item.frame_len >= FULL_LEN);
      q_cmd.row     = found_row;
      q_cmd.ident   = ident;
      q_cmd.len     = req_item.frame_len;
      q_cmd.data    = req_item.payload;
   end

endmodule

### hdl/cist_queue.sv
// Short command queue between front and back so each side stalls on its own.
// Depends on cist_pkg for the command type and depth.
`timescale 1ns / 1ps
module cist_queue import cist_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   input  logic    pop,
   output cmd_type dout,
   output logic    full,
   output logic    empty
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots need no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### hdl/cist_back.sv
// Back end: applies frame commands to the row memory and counters, and walks
// the table one row a cycle for a dump. Depends on cist_pkg.
`timescale 1ns / 1ps
module cist_back import cist_pkg::*; #(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  cmd_type      q_cmd,
   output logic         q_pop,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;

   back_state_type state_ff, state_in;
   logic [RowW-1:0] idx_ff, idx_in;
   logic [31:0]     count_ff, count_in;
   logic [28:0]     ident_ff, ident_in;
   logic [3:0]      len_ff, len_in;
   logic [ROWS-1:0] mark_ff, mark_in;

   // Row memory and its read pipeline
   logic [63:0]     mem [ROWS];
   logic            wr_en;
   logic [63:0]     rd_word_ff;
   logic            pv_ff, pv_in;
   logic [RowW-1:0] p_idx_ff;
   logic            p_mark_ff;
   logic            p_last_ff, last_issue;
   logic [63:0]     shown_word;

   assign last_issue = (idx_ff == RowW'(ROWS - 1));

   // Sequencer: pop one command when idle, walk rows while dumping
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      ident_in = ident_ff;
      len_in   = len_ff;
      mark_in  = mark_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      pv_in    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_cmd.is_dump) begin
                  state_in = BK_DUMP;
                  idx_in   = '0;
               end else begin
                  count_in = count_ff + 1'b1;
                  ident_in = q_cmd.ident;
                  len_in   = q_cmd.len;
                  if (q_cmd.hit) begin
                     wr_en                       = 1'b1;
                     mark_in[q_cmd.row[RowW-1:0]] = 1'b1;
                  end
               end
            end
         end
         BK_DUMP: begin
            pv_in = 1'b1;
            if (last_issue) begin
               state_in = BK_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         ident_ff <= '0;
         len_ff   <= '0;
         mark_ff  <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         ident_ff <= ident_in;
         len_ff   <= len_in;
         mark_ff  <= mark_in;
         pv_ff    <= pv_in;
      end
   end

   // Memory write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[q_cmd.row[RowW-1:0]] <= q_cmd.data;
      end
      rd_word_ff <= mem[idx_ff];
      p_idx_ff   <= idx_ff;
      p_mark_ff  <= mark_ff[idx_ff];
      p_last_ff  <= last_issue;
   end

   // Result beat; counters cannot move until the dump has been fully issued
   assign shown_word = p_mark_ff ? rd_word_ff : 64'd0;
   assign rsp_strobe = pv_ff;

   always_comb begin
      rsp_item.row_index    = 5'(p_idx_ff);
      rsp_item.row_ident    = row_ident_of(ROW_SEL_W'(p_idx_ff));
      rsp_item.row_valid    = p_mark_ff;
      rsp_item.word_high    = shown_word[63:32];
      rsp_item.word_low     = shown_word[31:0];
      rsp_item.frames_seen  = count_ff;
      rsp_item.recent_ident = ident_ff;
      rsp_item.recent_len   = len_ff;
      rsp_item.last_row     = p_last_ff;
   end

endmodule

### hdl/can_id_snapshot_table.sv
// CAN identifier snapshot table, top level: front end, command queue, back end.
// A frame beat is pushed into the command queue on accept and applied when the back
// end is idle and pops it; a dump, once popped, reads the rows through the registered
// read port and puts one row per cycle on the ports, ROWS rows. Frames are taken one
// per cycle while the queue has room; a dump holds the back end until its last row
// is issued. Reset clears marks, counters and queue at once.
`timescale 1ns / 1ps
module can_id_snapshot_table import cist_pkg::*; #(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   logic    q_push, q_pop, q_full, q_empty;
   cmd_type q_in, q_out;

   // Classify incoming beats
   cist_front #(.ROWS(ROWS)) u_front (
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_in)
   );

   cist_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in),
      .pop   (q_pop),
      .dout  (q_out),
      .full  (q_full),
      .empty (q_empty)
   );

   // Apply frames and walk the table
   cist_back #(.ROWS(ROWS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (q_out),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // Checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("queue pop while empty");

   a_rows_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last_row) |=> rsp_strobe)
      else $error("dump rows not back to back");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last_row) |-> (rsp_item.row_index == 5'(ROWS - 1)))
      else $error("last row flag on wrong row");

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the CAN identifier snapshot table: random and directed
// frame and dump beats, checked row by row against a shadow of the table.
// Depends on cist_pkg and can_id_snapshot_table.
`timescale 1ns / 1ps
module tb_top;
   import cist_pkg::*;

   localparam int TABLE_ROWS = ROWS_DEFAULT;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_BEATS = 160;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   can_id_snapshot_table #(.ROWS(TABLE_ROWS)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #2 clock = ~clock;

   // Beats waiting to go out, and rows the dumps should produce
   req_item_type pending_beats[$];
   rsp_item_type dump_rows_expected[$];
   int           fail_count = 0;

   // Shadow of the table and frame statistics
   logic [63:0] shadow_words [TABLE_ROWS];
   logic        shadow_marks [TABLE_ROWS];
   logic [31:0] shadow_count = '0;
   logic [28:0] shadow_ident = '0;
   logic [3:0]  shadow_len = '0;

   initial begin
      for (int r = 0; r < TABLE_ROWS; r++) begin
         shadow_words[r] = '0;
         shadow_marks[r] = 1'b0;
      end
   end

   // Fixed identifier per row; rows past the built-in list have none
   function automatic logic [10:0] table_ident(input int row);
      case (row)
         0:       return 11'h402;
         1:       return 11'h403;
         2:       return 11'h40B;
         3:       return 11'h40C;
         4:       return 11'h404;
         5:       return 11'h40E;
         6:       return 11'h405;
         7:       return 11'h406;
         8:       return 11'h407;
         9:       return 11'h422;
         10:      return 11'h423;
         11:      return 11'h42B;
         12:      return 11'h42C;
         13:      return 11'h424;
         14:      return 11'h42E;
         15:      return 11'h425;
         16:      return 11'h426;
         17:      return 11'h427;
         18:      return 11'h501;
         19:      return 11'h504;
         20:      return 11'h581;
         21:      return 11'h582;
         22:      return 11'h583;
         23:      return 11'h585;
         24:      return 11'h586;
         25:      return 11'h401;
         26:      return 11'h421;
         default: return 11'h000;
      endcase
   endfunction

   // Apply one accepted beat to the shadow; a dump queues every row it reports
   task automatic take_beat(input req_item_type beat);
      rsp_item_type row_beat;
      logic [28:0]  ident;
      logic         hit;
      hit = 1'b0;
      if (beat.req_type == REQ_FRAME) begin
         shadow_count = shadow_count + 32'd1;
         ident = beat.is_extended ? beat.frame_id : {18'd0, beat.frame_id[10:0]};
         shadow_ident = ident;
         shadow_len = beat.frame_len;
         if (!beat.is_extended && beat.frame_len >= FULL_LEN) begin
            for (int r = 0; r < TABLE_ROWS && r < BUILTIN_IDS; r++) begin
               if (!hit && table_ident(r) == ident[10:0]) begin
                  shadow_words[r] = beat.payload;
                  shadow_marks[r] = 1'b1;
                  hit = 1'b1;
               end
            end
         end
      end else begin
         for (int r = 0; r < TABLE_ROWS; r++) begin
            row_beat.row_index    = r[4:0];
            row_beat.row_ident    = table_ident(r);
            row_beat.row_valid    = shadow_marks[r];
            row_beat.word_high    = shadow_marks[r] ? shadow_words[r][63:32] : 32'd0;
            row_beat.word_low     = shadow_marks[r] ? shadow_words[r][31:0] : 32'd0;
            row_beat.frames_seen  = shadow_count;
            row_beat.recent_ident = shadow_ident;
            row_beat.recent_len   = shadow_len;
            row_beat.last_row     = (r == TABLE_ROWS - 1);
            dump_rows_expected.push_back(row_beat);
         end
      end
   endtask

   // Driver: present queued beats, with random gaps and gap-free bursts
   int gap_left = 0;
   int burst_left = 0;

   always @(posedge clock) begin
      int roll;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) take_beat(req_item);
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            req_item <= pending_beats.pop_front();
            start <= 1'b1;
            // gap to leave after this beat
            roll = $urandom_range(0, 99);
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
               gap_left = 0;
            end else if (roll < 5) begin
               burst_left = $urandom_range(10, 20);
               gap_left = 0;
            end else if (roll < 50) begin
               gap_left = 0;
            end else if (roll < 85) begin
               gap_left = $urandom_range(1, 3);
            end else if (roll < 97) begin
               gap_left = $urandom_range(4, 12);
            end else begin
               gap_left = $urandom_range(20, 60);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: every strobed row against the oldest expected row
   rsp_item_type row_want;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (dump_rows_expected.size() == 0) begin
            $display("%0t: unexpected row, expected none, actual %h", $time, rsp_item);
            fail_count++;
         end else begin
            row_want = dump_rows_expected.pop_front();
            check_field("row_index", row_want.row_index, rsp_item.row_index);
            check_field("row_ident", row_want.row_ident, rsp_item.row_ident);
            check_field("row_valid", row_want.row_valid, rsp_item.row_valid);
            check_field("word_high", row_want.word_high, rsp_item.word_high);
            check_field("word_low", row_want.word_low, rsp_item.word_low);
            check_field("frames_seen", row_want.frames_seen, rsp_item.frames_seen);
            check_field("recent_ident", row_want.recent_ident, rsp_item.recent_ident);
            check_field("recent_len", row_want.recent_len, rsp_item.recent_len);
            check_field("last_row", row_want.last_row, rsp_item.last_row);
         end
      end
   end

   task automatic push_beat(input logic kind, input logic [28:0] id, input logic ext,
                            input logic [3:0] len, input logic [63:0] data);
      req_item_type beat;
      beat.req_type    = kind;
      beat.frame_id    = id;
      beat.is_extended = ext;
      beat.frame_len   = len;
      beat.payload     = data;
      pending_beats.push_back(beat);
   endtask

   // Stimulus, then drain and verdict
   initial begin
      int          roll;
      int          row;
      logic [28:0] id;
      logic [3:0]  len;

      // directed: empty table, extremes, each corner of the store rule
      push_beat(REQ_DUMP, 29'h1FFFFFFF, 1'b1, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
      push_beat(REQ_FRAME, 29'h402, 1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      push_beat(REQ_FRAME, 29'h421, 1'b0, 4'd15, 64'h0123_4567_89AB_CDEF);
      push_beat(REQ_FRAME, 29'h403, 1'b1, 4'd8, 64'h1111_2222_3333_4444);
      push_beat(REQ_FRAME, 29'h40B, 1'b0, 4'd7, 64'h5555_6666_7777_8888);
      push_beat(REQ_FRAME, 29'h1FFFF501, 1'b0, 4'd8, 64'hA5A5_5A5A_C3C3_3C3C);
      push_beat(REQ_FRAME, 29'h7FF, 1'b0, 4'd8, 64'hDEAD_BEEF_CAFE_F00D);
      push_beat(REQ_DUMP, 29'h0, 1'b0, 4'd0, 64'h0);
      push_beat(REQ_FRAME, 29'h402, 1'b0, 4'd8, 64'h0);
      push_beat(REQ_FRAME, 29'h0, 1'b0, 4'd0, 64'h0);
      push_beat(REQ_FRAME, 29'h404, 1'b1, 4'd8, 64'h9999_AAAA_BBBB_CCCC);
      push_beat(REQ_FRAME, 29'h586, 1'b0, 4'd9, 64'h8000_0000_0000_0001);
      push_beat(REQ_DUMP, 29'h155, 1'b1, 4'd3, 64'h1234_5678_9ABC_DEF0);
      push_beat(REQ_FRAME, 29'h1FFFFFFF, 1'b1, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_beat(REQ_DUMP, 29'h0, 1'b0, 4'd0, 64'h0);
      push_beat(REQ_DUMP, 29'h0, 1'b0, 4'd0, 64'h0);

      // random: mostly matching full frames, some noise, dumps now and then
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         roll = $urandom_range(0, 99);
         row = $urandom_range(0, BUILTIN_IDS - 1);
         id = {18'd0, table_ident(row)};
         if (roll < 12) begin
            push_beat(REQ_DUMP, 29'($urandom()), 1'($urandom()), 4'($urandom()),
                      {$urandom(), $urandom()});
         end else if (roll < 70) begin
            if ($urandom_range(0, 3) == 0) id[28:11] = 18'($urandom());
            len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
            push_beat(REQ_FRAME, id, 1'b0, len, {$urandom(), $urandom()});
         end else if (roll < 80) begin
            push_beat(REQ_FRAME, 29'($urandom()), 1'b1, 4'($urandom()),
                      {$urandom(), $urandom()});
         end else if (roll < 90) begin
            push_beat(REQ_FRAME, id, 1'b0, 4'($urandom_range(0, 7)),
                      {$urandom(), $urandom()});
         end else begin
            push_beat(REQ_FRAME, 29'($urandom()), 1'($urandom()), 4'($urandom()),
                      {$urandom(), $urandom()});
         end
      end
      push_beat(REQ_DUMP, 29'h0, 1'b0, 4'd0, 64'h0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wait until every beat is taken and every row has come back
      do @(posedge clock);
      while (pending_beats.size() != 0 || start || gap_left != 0 ||
             dump_rows_expected.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && dump_rows_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
hdl/cist_pkg.sv
hdl/cist_front.sv
hdl/cist_queue.sv
hdl/cist_back.sv
hdl/can_id_snapshot_table.sv
tb/sv/tb_top.sv
